// ===== design/bpq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Bucketed priority queue - shared definitions
// Default sizes, operation codes, sequencer states and the per-level cell
// control word used by the top level and the level cells.
// ----------------------------------------------------------------------------
package bpq_pkg;

   localparam int DEF_LEVELS      = 8;
   localparam int DEF_CAPACITY    = 64;
   localparam int DEF_VALUE_WIDTH = 32;

   // Operation codes carried on the request channel.
   localparam logic FUNC_ENQUEUE = 1'b0;
   localparam logic FUNC_DEQUEUE = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_UPDATE
   } state_type;

   // Update command for one level cell, valid only in the cycle it commits.
   typedef struct packed {
      logic enq_hit;
      logic deq_hit;
   } cell_ctrl_type;

endpackage
`default_nettype wire

// ===== design/bucketed_priority_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Bucketed priority queue
// One FIFO per priority level in a shared linked store; level zero is the
// most urgent. Each request enqueues a value or dequeues the oldest value of
// the most urgent occupied level, and returns one response.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake               Carries
//   req      req_valid / req_ready   func, item value, item priority
//   rsp      rsp_valid / rsp_ready   taken value, head value and level,
//                                    empty flag, entry count, reject flag
//   csr      csr_wr_en               lowest accepted priority level
//
// A request goes through a read state, for the registered read of the link
// store and the free-slot stack, and an update state, which registers the
// response; a new request is taken in the update cycle. Reset clears the
// level occupancy and the counters and sets the register to the last level;
// no store is swept, so the queue is usable in the cycle after reset. A
// stalled response holds the update cycle until the response transfer
// completes.
// ----------------------------------------------------------------------------
module bucketed_priority_queue #(
   parameter int LEVELS      = bpq_pkg::DEF_LEVELS,
   parameter int CAPACITY    = bpq_pkg::DEF_CAPACITY,
   parameter int VALUE_WIDTH = bpq_pkg::DEF_VALUE_WIDTH
) (
   input  wire logic                            clock,
   input  wire logic                            reset,

   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic                            req_func,
   input  wire logic [VALUE_WIDTH-1:0]          req_item_value,
   input  wire logic [$clog2(LEVELS)-1:0]       req_item_priority,

   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic      [VALUE_WIDTH-1:0]          rsp_taken_value,
   output logic      [VALUE_WIDTH-1:0]          rsp_head_value,
   output logic      [$clog2(LEVELS)-1:0]       rsp_head_priority,
   output logic                                 rsp_queue_empty,
   output logic      [$clog2(CAPACITY+1)-1:0]   rsp_entry_count,
   output logic                                 rsp_rejected,

   input  wire logic                            csr_wr_en,
   input  wire logic [$clog2(LEVELS)-1:0]       csr_wr_data
);

   import bpq_pkg::*;

   localparam int SLOT_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int LVL_W  = $clog2(LEVELS);
   localparam int LINK_W = SLOT_W + VALUE_WIDTH;

   // Sequencer and request registers.
   state_type              state_ff, state_in;
   logic                   func_ff;
   logic [VALUE_WIDTH-1:0] value_ff;
   logic [LVL_W-1:0]       level_ff;
   logic                   accept;
   logic                   commit;

   // Configuration, counters and response registers.
   logic [LVL_W-1:0]       lowest_ff, lowest_in;
   logic [CNT_W-1:0]       total_ff,  total_in;
   logic [CNT_W-1:0]       peak_ff,   peak_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0] taken_ff,  taken_in;
   logic                   rejected_ff, rejected_in;

   // Level cell chain.
   logic [LEVELS:0]        found_w;
   logic [LVL_W-1:0]       level_w [LEVELS+1];
   logic [SLOT_W-1:0]      head_w  [LEVELS+1];
   logic [VALUE_WIDTH-1:0] hval_w  [LEVELS+1];
   logic [LEVELS-1:0]      occ_w;
   logic [SLOT_W-1:0]      tail_w  [LEVELS];
   cell_ctrl_type          ctrl_w  [LEVELS];

   // Store ports and decode.
   logic                   enq_ok;
   logic                   deq_ok;
   logic [SLOT_W-1:0]      new_slot;
   logic [CNT_W-1:0]       total_dec;
   logic                   link_wr_en;
   logic [SLOT_W-1:0]      link_wr_addr;
   logic [LINK_W-1:0]      link_wr_data;
   logic [LINK_W-1:0]      link_rd_data;
   logic                   free_wr_en;
   logic [SLOT_W-1:0]      free_rd_data;
   logic                   rd_en;

   // -------------------------------------------------------------------------
   // Sequencer: idle, read the stores, then update. The update cycle also
   // takes the next request, which then goes straight to the read state. The
   // update waits while the previous response is still unclaimed.
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      commit    = 1'b0;
      rd_en     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               commit    = 1'b1;
               req_ready = 1'b1;
               state_in  = req_valid ? ST_READ : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign accept = req_valid && req_ready;

   // The request is held through its read and update states.
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff  <= req_func;
         value_ff <= req_item_value;
         level_ff <= req_item_priority;
      end
   end

   // -------------------------------------------------------------------------
   // Level cells. The chain starts empty and each occupied cell that sees no
   // more urgent occupied level ahead of it places its head on the chain, so
   // the far end carries the head of the queue, or zeros when it is empty.
   // -------------------------------------------------------------------------
   assign found_w[0] = 1'b0;
   assign level_w[0] = '0;
   assign head_w[0]  = '0;
   assign hval_w[0]  = '0;

   for (genvar i = 0; i < LEVELS; i++) begin : g_cell
      assign ctrl_w[i].enq_hit = commit && enq_ok && (level_ff == LVL_W'(i));
      assign ctrl_w[i].deq_hit = commit && deq_ok && (level_w[LEVELS] == LVL_W'(i));

      bpq_level_cell #(
         .LEVELS      (LEVELS),
         .CAPACITY    (CAPACITY),
         .VALUE_WIDTH (VALUE_WIDTH),
         .IDX         (i)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctrl          (ctrl_w[i]),
         .new_slot      (new_slot),
         .new_value     (value_ff),
         .link_slot     (link_rd_data[LINK_W-1 -: SLOT_W]),
         .link_value    (link_rd_data[VALUE_WIDTH-1:0]),
         .found_in      (found_w[i]),
         .sel_level_in  (level_w[i]),
         .sel_head_in   (head_w[i]),
         .sel_value_in  (hval_w[i]),
         .found_out     (found_w[i+1]),
         .sel_level_out (level_w[i+1]),
         .sel_head_out  (head_w[i+1]),
         .sel_value_out (hval_w[i+1]),
         .occupied      (occ_w[i]),
         .tail_slot     (tail_w[i])
      );
   end

   // -------------------------------------------------------------------------
   // Update decode.
   // An enqueue is refused above the configured level, beyond the last level
   // or into a full store; a dequeue is refused when nothing is stored.
   // Free slots form a stack whose free part sits at addresses from the
   // entry count upwards. Addresses at or above the highest count ever
   // reached were never written and stand for their own slot number.
   // -------------------------------------------------------------------------
   always_comb begin
      enq_ok = (func_ff == FUNC_ENQUEUE)
            && (level_ff <= lowest_ff)
            && ({1'b0, level_ff} < (LVL_W+1)'(LEVELS))
            && (total_ff != CNT_W'(CAPACITY));
      deq_ok = (func_ff == FUNC_DEQUEUE) && found_w[LEVELS];

      new_slot  = (peak_ff > total_ff) ? free_rd_data : total_ff[SLOT_W-1:0];
      total_dec = total_ff - CNT_W'(1);

      // Appending to an occupied level links the old tail to the new slot and
      // keeps the new value beside the link, so a dequeue finds the next head
      // and its value in one read.
      link_wr_en   = commit && enq_ok && occ_w[level_ff];
      link_wr_addr = tail_w[level_ff];
      link_wr_data = {new_slot, value_ff};

      free_wr_en = commit && deq_ok;

      total_in     = total_ff;
      peak_in      = peak_ff;
      taken_in     = taken_ff;
      rejected_in  = rejected_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (commit) begin
         rsp_valid_in = 1'b1;
         rejected_in  = !(enq_ok || deq_ok);
         taken_in     = deq_ok ? hval_w[LEVELS] : '0;
         if (enq_ok) begin
            total_in = total_ff + CNT_W'(1);
            if (total_ff == peak_ff) begin
               peak_in = peak_ff + CNT_W'(1);
            end
         end else if (deq_ok) begin
            total_in = total_dec;
         end
      end

      lowest_in = csr_wr_en ? csr_wr_data : lowest_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lowest_ff    <= LVL_W'(LEVELS - 1);
         total_ff     <= '0;
         peak_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         lowest_ff    <= lowest_in;
         total_ff     <= total_in;
         peak_ff      <= peak_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      taken_ff    <= taken_in;
      rejected_ff <= rejected_in;
   end

   // -------------------------------------------------------------------------
   // Stores. Both are read in the read cycle and written in the update cycle,
   // so a read never meets a write to the same store.
   // -------------------------------------------------------------------------
   bpq_ram #(
      .WIDTH (LINK_W),
      .DEPTH (CAPACITY)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_wr_en),
      .wr_addr (link_wr_addr),
      .wr_data (link_wr_data),
      .rd_en   (rd_en),
      .rd_addr (head_w[LEVELS]),
      .rd_data (link_rd_data)
   );

   bpq_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (CAPACITY)
   ) u_free_ram (
      .clock   (clock),
      .wr_en   (free_wr_en),
      .wr_addr (total_dec[SLOT_W-1:0]),
      .wr_data (head_w[LEVELS]),
      .rd_en   (rd_en),
      .rd_addr (total_ff[SLOT_W-1:0]),
      .rd_data (free_rd_data)
   );

   // -------------------------------------------------------------------------
   // Response. The head fields come straight from the level chain and the
   // count from the counter: the queue state only changes at an update, and
   // an update only completes once the pending response has gone, so these
   // fields hold for as long as the response waits.
   // -------------------------------------------------------------------------
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_taken_value   = taken_ff;
   assign rsp_head_value    = hval_w[LEVELS];
   assign rsp_head_priority = level_w[LEVELS];
   assign rsp_queue_empty   = (total_ff == '0);
   assign rsp_entry_count   = total_ff;
   assign rsp_rejected      = rejected_ff;

`ifndef SYNTH
   // The entry count never exceeds the store.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CNT_W'(CAPACITY))
      else $error("entry count beyond capacity");

   // The count and the level occupancy agree on emptiness.
   a_empty_agree: assert property (@(posedge clock) disable iff (reset)
      (total_ff == '0) == !found_w[LEVELS])
      else $error("entry count and level occupancy disagree");

   // The free-stack high-water mark never falls below the count.
   a_peak_bound: assert property (@(posedge clock) disable iff (reset)
      peak_ff >= total_ff)
      else $error("free-stack high-water mark below entry count");

   // A dequeue that is carried out removes exactly one entry.
   a_deq_count: assert property (@(posedge clock) disable iff (reset)
      (commit && deq_ok) |=> (total_ff == $past(total_ff) - CNT_W'(1)))
      else $error("dequeue did not remove one entry");
`endif

endmodule
`default_nettype wire

// ===== design/bpq_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== design/bpq_level_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Bucketed priority queue - level cell
// Holds the head slot, tail slot, head value and occupancy of one level, and
// passes the most urgent occupied level along the chain.
// ----------------------------------------------------------------------------
module bpq_level_cell #(
   parameter int LEVELS      = bpq_pkg::DEF_LEVELS,
   parameter int CAPACITY    = bpq_pkg::DEF_CAPACITY,
   parameter int VALUE_WIDTH = bpq_pkg::DEF_VALUE_WIDTH,
   parameter int IDX         = 0
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire bpq_pkg::cell_ctrl_type        ctrl,
   input  wire logic [$clog2(CAPACITY)-1:0]   new_slot,
   input  wire logic [VALUE_WIDTH-1:0]        new_value,
   input  wire logic [$clog2(CAPACITY)-1:0]   link_slot,
   input  wire logic [VALUE_WIDTH-1:0]        link_value,
   input  wire logic                          found_in,
   input  wire logic [$clog2(LEVELS)-1:0]     sel_level_in,
   input  wire logic [$clog2(CAPACITY)-1:0]   sel_head_in,
   input  wire logic [VALUE_WIDTH-1:0]        sel_value_in,
   output logic                               found_out,
   output logic      [$clog2(LEVELS)-1:0]     sel_level_out,
   output logic      [$clog2(CAPACITY)-1:0]   sel_head_out,
   output logic      [VALUE_WIDTH-1:0]        sel_value_out,
   output logic                               occupied,
   output logic      [$clog2(CAPACITY)-1:0]   tail_slot
);

   import bpq_pkg::*;

   localparam int SLOT_W = $clog2(CAPACITY);
   localparam int LVL_W  = $clog2(LEVELS);

   logic                   occ_ff,   occ_in;
   logic [SLOT_W-1:0]      head_ff,  head_in;
   logic [SLOT_W-1:0]      tail_ff,  tail_in;
   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic                   take;

   // An enqueue appends behind the tail, or starts the list when the level is
   // empty. A dequeue either empties the level or moves the head one link on.
   always_comb begin
      occ_in   = occ_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      value_in = value_ff;
      if (ctrl.enq_hit) begin
         tail_in = new_slot;
         if (!occ_ff) begin
            occ_in   = 1'b1;
            head_in  = new_slot;
            value_in = new_value;
         end
      end else if (ctrl.deq_hit) begin
         if (head_ff == tail_ff) begin
            occ_in = 1'b0;
         end else begin
            head_in  = link_slot;
            value_in = link_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff  <= head_in;
      tail_ff  <= tail_in;
      value_ff <= value_in;
   end

   // The first occupied cell along the chain claims the selection.
   assign take          = occ_ff && !found_in;
   assign found_out     = found_in || occ_ff;
   assign sel_level_out = take ? LVL_W'(IDX) : sel_level_in;
   assign sel_head_out  = take ? head_ff : sel_head_in;
   assign sel_value_out = take ? value_ff : sel_value_in;

   assign occupied  = occ_ff;
   assign tail_slot = tail_ff;

endmodule
`default_nettype wire

// ===== sim/bpq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bucketed priority queue - response checker
// Watches the request, response and register ports of the queue. It keeps
// its own picture of the stored entries, forecasts each response and
// compares every response transfer, field by field, with the oldest forecast.
// ----------------------------------------------------------------------------
module bpq_checker #(
   parameter int LEVEL_BITS = $clog2(bpq_pkg::DEF_LEVELS),
   parameter int COUNT_BITS = $clog2(bpq_pkg::DEF_CAPACITY + 1)
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   input  wire logic                                  req_ready,
   input  wire logic                                  req_func,
   input  wire logic [bpq_pkg::DEF_VALUE_WIDTH-1:0]   req_item_value,
   input  wire logic [LEVEL_BITS-1:0]                 req_item_priority,
   input  wire logic                                  rsp_valid,
   input  wire logic                                  rsp_ready,
   input  wire logic [bpq_pkg::DEF_VALUE_WIDTH-1:0]   rsp_taken_value,
   input  wire logic [bpq_pkg::DEF_VALUE_WIDTH-1:0]   rsp_head_value,
   input  wire logic [LEVEL_BITS-1:0]                 rsp_head_priority,
   input  wire logic                                  rsp_queue_empty,
   input  wire logic [COUNT_BITS-1:0]                 rsp_entry_count,
   input  wire logic                                  rsp_rejected,
   input  wire logic                                  csr_wr_en,
   input  wire logic [LEVEL_BITS-1:0]                 csr_wr_data,
   output int                                         fault_count,
   output int                                         outstanding
);

   import bpq_pkg::*;

   typedef struct packed {
      logic [LEVEL_BITS-1:0]      lvl;
      logic [DEF_VALUE_WIDTH-1:0] val;
   } held_entry_type;

   typedef struct packed {
      logic [DEF_VALUE_WIDTH-1:0] taken_value;
      logic [DEF_VALUE_WIDTH-1:0] head_value;
      logic [LEVEL_BITS-1:0]      head_priority;
      logic                       queue_empty;
      logic [COUNT_BITS-1:0]      entry_count;
      logic                       rejected;
   } queue_outcome_type;

   // Entries in arrival order; the head is the first entry of the lowest level.
   held_entry_type        held_entries[$];
   queue_outcome_type     outcome_forecast[$];
   logic [LEVEL_BITS-1:0] level_limit;

   initial begin
      fault_count = 0;
      outstanding = 0;
      level_limit = LEVEL_BITS'(DEF_LEVELS - 1);
   end

   task automatic report_mismatch(input string what, input logic [63:0] want,
                                  input logic [63:0] got);
      if (fault_count < 100) begin
         $display("%0t ns bpq_checker: %s expected %0h got %0h", $time, what, want, got);
      end
      fault_count++;
   endtask

   function automatic int find_head();
      int at;
      at = -1;
      foreach (held_entries[i]) begin
         if (at < 0 || held_entries[i].lvl < held_entries[at].lvl) begin
            at = i;
         end
      end
      return at;
   endfunction

   function automatic queue_outcome_type apply_queue_op(input logic op,
                                                        input logic [DEF_VALUE_WIDTH-1:0] value,
                                                        input logic [LEVEL_BITS-1:0] level);
      queue_outcome_type res;
      int                head_at;
      res = '0;
      if (op == FUNC_ENQUEUE) begin
         if (level > level_limit || held_entries.size() >= DEF_CAPACITY) begin
            res.rejected = 1'b1;
         end else begin
            held_entries.push_back('{lvl: level, val: value});
         end
      end else begin
         head_at = find_head();
         if (head_at < 0) begin
            res.rejected = 1'b1;
         end else begin
            res.taken_value = held_entries[head_at].val;
            held_entries.delete(head_at);
         end
      end
      head_at = find_head();
      if (head_at >= 0) begin
         res.head_value    = held_entries[head_at].val;
         res.head_priority = held_entries[head_at].lvl;
      end
      res.queue_empty = (held_entries.size() == 0);
      res.entry_count = COUNT_BITS'(held_entries.size());
      return res;
   endfunction

   always @(posedge clock) begin : watch
      queue_outcome_type want;
      if (reset) begin
         held_entries.delete();
         outcome_forecast.delete();
         level_limit = LEVEL_BITS'(DEF_LEVELS - 1);
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (outcome_forecast.size() == 0) begin
               report_mismatch("response with nothing pending, taken", 0, rsp_taken_value);
            end else begin
               want = outcome_forecast.pop_front();
               if (rsp_taken_value !== want.taken_value)
                  report_mismatch("taken_value", want.taken_value, rsp_taken_value);
               if (rsp_head_value !== want.head_value)
                  report_mismatch("head_value", want.head_value, rsp_head_value);
               if (rsp_head_priority !== want.head_priority)
                  report_mismatch("head_priority", want.head_priority, rsp_head_priority);
               if (rsp_queue_empty !== want.queue_empty)
                  report_mismatch("queue_empty", want.queue_empty, rsp_queue_empty);
               if (rsp_entry_count !== want.entry_count)
                  report_mismatch("entry_count", want.entry_count, rsp_entry_count);
               if (rsp_rejected !== want.rejected)
                  report_mismatch("rejected", want.rejected, rsp_rejected);
            end
         end
         if (csr_wr_en) begin
            level_limit = csr_wr_data;
         end
         if (req_valid && req_ready) begin
            outcome_forecast.push_back(apply_queue_op(req_func, req_item_value,
                                                      req_item_priority));
         end
      end
      outstanding <= outcome_forecast.size();
   end

endmodule

// ===== sim/bucketed_priority_queue_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bucketed priority queue - testbench top
// Drives enqueue and dequeue requests and register writes into the queue,
// idles both channels at random and gives the verdict; the checker beside the
// block forecasts and compares every response.
// ----------------------------------------------------------------------------
module bucketed_priority_queue_tb;
   import bpq_pkg::*;

   localparam int LEVEL_BITS    = $clog2(DEF_LEVELS);
   localparam int COUNT_BITS    = $clog2(DEF_CAPACITY + 1);
   // Far beyond the slowest clean run: about a thousand transfers, plus the
   // long hold-off on the response side.
   localparam int CYCLE_LIMIT   = 200000;
   localparam int LONG_HOLD     = 300;
   localparam int PHASE_ITEMS   = 125;
   localparam int IDLE_PERCENT  = 27;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;

   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic                        req_func = FUNC_ENQUEUE;
   logic [DEF_VALUE_WIDTH-1:0]  req_item_value = '0;
   logic [LEVEL_BITS-1:0]       req_item_priority = '0;

   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [DEF_VALUE_WIDTH-1:0]  rsp_taken_value;
   logic [DEF_VALUE_WIDTH-1:0]  rsp_head_value;
   logic [LEVEL_BITS-1:0]       rsp_head_priority;
   logic                        rsp_queue_empty;
   logic [COUNT_BITS-1:0]       rsp_entry_count;
   logic                        rsp_rejected;

   logic                        csr_wr_en = 1'b0;
   logic [LEVEL_BITS-1:0]       csr_wr_data = '0;

   // A calm phase switches idling off on both sides; the hold-off request
   // asks the response side for one long stall.
   logic                        calm_phase = 1'b0;
   logic                        long_hold_asked = 1'b0;
   logic                        long_hold_done = 1'b0;
   int                          hold_left = 0;
   int                          cycle_count = 0;
   int                          fault_count;
   int                          outstanding;

   always #5 clock = ~clock;

   bucketed_priority_queue uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_item_value    (req_item_value),
      .req_item_priority (req_item_priority),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_taken_value   (rsp_taken_value),
      .rsp_head_value    (rsp_head_value),
      .rsp_head_priority (rsp_head_priority),
      .rsp_queue_empty   (rsp_queue_empty),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_rejected      (rsp_rejected),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   bpq_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_item_value    (req_item_value),
      .req_item_priority (req_item_priority),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_taken_value   (rsp_taken_value),
      .rsp_head_value    (rsp_head_value),
      .rsp_head_priority (rsp_head_priority),
      .rsp_queue_empty   (rsp_queue_empty),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_rejected      (rsp_rejected),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .fault_count       (fault_count),
      .outstanding       (outstanding)
   );

   // Response side. Ready is withdrawn at random, except in a calm phase. When
   // the long hold-off is asked for, ready stays low through it while the
   // request side keeps offering, so the block fills and stalls its input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (long_hold_asked && !long_hold_done) begin
         long_hold_done <= 1'b1;
         hold_left      <= LONG_HOLD;
         rsp_ready      <= 1'b0;
      end else begin
         rsp_ready <= calm_phase || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // Watchdog: a run that hangs is a failed run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("bucketed_priority_queue_tb: done, errors");
         $finish;
      end
   end

   // Offers one request and returns at the edge of its transfer. Valid is left
   // high so that back-to-back requests need no second assignment in a step;
   // an idle gap, when one is drawn, lowers it first.
   task automatic send_op(input logic op, input logic [DEF_VALUE_WIDTH-1:0] value,
                          input logic [LEVEL_BITS-1:0] level);
      while (!calm_phase && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_func          <= op;
      req_item_value    <= value;
      req_item_priority <= level;
      do @(posedge clock); while (!req_ready);
   endtask

   // Waits until every forecast response has arrived and the block has had
   // time to settle, so the register is only written while the queue is idle.
   task automatic drain_responses();
      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_level_limit(input logic [LEVEL_BITS-1:0] limit);
      drain_responses();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= limit;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin : stimulus
      int                    limit_plan[8];
      int                    enqueue_percent;
      logic [LEVEL_BITS-1:0] level;
      limit_plan = '{7, 7, 3, 0, 5, 7, 1, 7};

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part. A dequeue on the empty queue must be refused; then the
      // value and level extremes, with two entries sharing level zero so that
      // first-in, first-out order within a level shows.
      send_op(FUNC_DEQUEUE, $urandom, LEVEL_BITS'($urandom_range(7)));
      send_op(FUNC_ENQUEUE, 32'hFFFF_FFFF, 3'd7);
      send_op(FUNC_ENQUEUE, 32'h0000_0000, 3'd0);
      send_op(FUNC_ENQUEUE, 32'h5555_AAAA, 3'd3);
      send_op(FUNC_ENQUEUE, 32'hAAAA_5555, 3'd0);
      send_op(FUNC_ENQUEUE, 32'h0000_0001, 3'd7);
      repeat (5) send_op(FUNC_DEQUEUE, $urandom, LEVEL_BITS'($urandom_range(7)));
      send_op(FUNC_DEQUEUE, 32'hFFFF_FFFF, 3'd7);

      // Register at its lowest: only level zero may be enqueued.
      set_level_limit(3'd0);
      send_op(FUNC_ENQUEUE, 32'h1234_5678, 3'd1);
      send_op(FUNC_ENQUEUE, 32'h8765_4321, 3'd7);
      send_op(FUNC_ENQUEUE, 32'hDEAD_BEEF, 3'd0);

      // Entries stored above a lowered register must still come out in level
      // order, while new enqueues above it are refused.
      set_level_limit(3'd7);
      send_op(FUNC_ENQUEUE, 32'h0F0F_0F0F, 3'd6);
      send_op(FUNC_ENQUEUE, 32'hF0F0_F0F0, 3'd5);
      set_level_limit(3'd2);
      send_op(FUNC_ENQUEUE, 32'h3333_3333, 3'd3);
      repeat (3) send_op(FUNC_DEQUEUE, $urandom, LEVEL_BITS'($urandom_range(7)));

      // Random part. Phases alternate between mostly enqueues, which run the
      // store into its full state, and mostly dequeues, which drain it to empty.
      // Most enqueue levels fall within the register so that entries build up.
      for (int phase = 0; phase < 8; phase++) begin
         set_level_limit(LEVEL_BITS'(limit_plan[phase]));
         calm_phase      <= (phase == 2);
         long_hold_asked <= (phase == 0);
         enqueue_percent = (phase % 2 == 0) ? 80 : 20;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(99) < enqueue_percent) begin
               if ($urandom_range(99) < 70)
                  level = LEVEL_BITS'($urandom_range(limit_plan[phase]));
               else
                  level = LEVEL_BITS'($urandom_range(7));
               send_op(FUNC_ENQUEUE, $urandom, level);
            end else begin
               send_op(FUNC_DEQUEUE, $urandom, LEVEL_BITS'($urandom_range(7)));
            end
         end
      end

      // Let the last responses through, then leave time for anything unexpected
      // to show up.
      drain_responses();
      repeat (8) @(posedge clock);
      if (fault_count == 0) begin
         $display("bucketed_priority_queue_tb: done, clean");
      end else begin
         $display("bucketed_priority_queue_tb: done, errors");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/bpq_pkg.sv
design/bpq_ram.sv
design/bpq_level_cell.sv
design/bucketed_priority_queue.sv
sim/bpq_checker.sv
sim/bucketed_priority_queue_tb.sv
